// File: hdl/assert_macros.svh
// assertion macros used by the checker file
// depends on nothing; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define KCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kcm assertion failed");

// next-cycle implication, disabled while in reset
`define KCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kcm assertion failed");

`endif

// File: hdl/kcm_pkg.sv
// types and codes for the kmp code point stream matcher
// depends on nothing
package kcm_pkg;

  localparam int unsigned CP_W      = 21;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned SEEN_W    = 48;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DW    = 7;
  localparam logic [LEN_W-1:0] MAX_PATTERN_RST = 7'd64;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_TEXT    = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_OVER  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 1'd0,
    REG_MAX_PATTERN    = 1'd1
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_RD,
    ST_T_CMP,
    ST_L_RDF,
    ST_L_GETF,
    ST_L_RD,
    ST_L_CMP,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

// File: hdl/kcm_stream_if.sv
// request and response channel interfaces of the matcher
// depends on kcm_pkg
interface kcm_req_if #(
  parameter int unsigned OFFSET_BITS = 48
);
  import kcm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             req_type;
  logic [IDX_W-1:0]       entry_index;
  logic [CP_W-1:0]        codepoint;
  logic [OFFSET_BITS-1:0] begin_ofs;
  logic [OFFSET_BITS-1:0] end_ofs;

  modport source (output valid, req_type, entry_index, codepoint, begin_ofs, end_ofs,
                  input ready);
  modport sink (input valid, req_type, entry_index, codepoint, begin_ofs, end_ofs,
                output ready);
endinterface

interface kcm_rsp_if #(
  parameter int unsigned OFFSET_BITS = 48
);
  import kcm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic                   found;
  logic [OFFSET_BITS-1:0] match_start;
  logic [OFFSET_BITS-1:0] match_end;
  logic [SEEN_W-1:0]      seen_count;

  modport source (output valid, status, found, match_start, match_end, seen_count,
                  input ready);
  modport sink (input valid, status, found, match_start, match_end, seen_count,
                output ready);
endinterface

// File: hdl/kcm_span_cell.sv
// one cell of the span chain: holds a span, shifts it on, and folds a running min/max
// depends on nothing
module kcm_span_cell #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic                   clk_i,
  input  logic                   shift_i,
  input  logic                   use_i,
  input  logic [OFFSET_BITS-1:0] in_start_i,
  input  logic [OFFSET_BITS-1:0] in_end_i,
  input  logic [OFFSET_BITS-1:0] acc_lo_i,
  input  logic [OFFSET_BITS-1:0] acc_hi_i,
  output logic [OFFSET_BITS-1:0] start_o,
  output logic [OFFSET_BITS-1:0] end_o,
  output logic [OFFSET_BITS-1:0] acc_lo_o,
  output logic [OFFSET_BITS-1:0] acc_hi_o
);

  logic [OFFSET_BITS-1:0] start_q, end_q, acc_lo_q, acc_hi_q;

  // span shift from the neighbor
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      start_q <= in_start_i;
      end_q   <= in_end_i;
    end
  end

  // fold own span into the value coming from the far end of the chain
  always_ff @(posedge clk_i) begin
    acc_lo_q <= (use_i && start_q < acc_lo_i) ? start_q : acc_lo_i;
    acc_hi_q <= (use_i && end_q > acc_hi_i) ? end_q : acc_hi_i;
  end

  assign start_o  = start_q;
  assign end_o    = end_q;
  assign acc_lo_o = acc_lo_q;
  assign acc_hi_o = acc_hi_q;

endmodule

// File: hdl/kmp_codepoint_stream_matcher.sv
// top level: kmp sequencer, pattern and failure memories, span cell chain
// depends on kcm_pkg, kcm_stream_if, kcm_span_cell
//
// channel | dir | payload
// req_i   | in  | req_type, entry_index, codepoint, begin_ofs, end_ofs
// rsp_o   | out | status, found, match_start, match_end, seen_count
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// requests are taken only while idle, one at a time; text compares the pattern
// entry, falls back via the failure memory on a mismatch, scans the span chain on
// a full match; load at index 0 writes both memories, else it fetches a failure
// entry and compares candidates; restart, ignored text, unused code go to done
// reset clears control, configuration and match state; memories and span chain are not reset
// the last cycle of a request stalls while the response register is full and not taken
module kmp_codepoint_stream_matcher #(
  parameter int unsigned PATTERN_MAX = 64,
  parameter int unsigned OFFSET_BITS = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  kcm_req_if.sink                           req_i,
  kcm_rsp_if.source                         rsp_o,
  input  logic                              cfg_we_i,
  input  logic [kcm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [kcm_pkg::CFG_DW-1:0]        cfg_data_i
);
  import kcm_pkg::*;

  localparam int unsigned AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned CW = $clog2(PATTERN_MAX + 1);

  state_e state_q, state_d;

  logic [LEN_W-1:0]       pat_len_q, max_pat_q;
  logic [CW-1:0]          m_q, cand_q, cnt_q;
  logic [SEEN_W-1:0]      seen_q;
  logic                   found_q;
  logic [OFFSET_BITS-1:0] fstart_q, fend_q;
  logic [CP_W-1:0]        cp_q;
  logic [IDX_W-1:0]       idx_q;

  logic                   rsp_valid_q;
  logic [1:0]             rsp_status_q;
  logic                   rsp_found_q;
  logic [OFFSET_BITS-1:0] rsp_start_q, rsp_end_q;
  logic [SEEN_W-1:0]      rsp_seen_q;

  logic [CP_W-1:0] pat_mem [PATTERN_MAX];
  logic [CW-1:0]   fail_mem [PATTERN_MAX];
  logic [CP_W-1:0] pat_rd_q;
  logic [CW-1:0]   fail_rd_q;
  logic [AW-1:0]   pat_raddr, fail_raddr, fail_waddr;
  logic            pat_we, fail_we;
  logic [CW-1:0]   fail_wdata;

  status_e status;
  logic    accept, idx_ok, slot_free, cp_eq;
  logic [CW-1:0] cand_next, m_next;

  // pattern status from the registers
  always_comb begin
    if (pat_len_q == '0) begin
      status = STAT_EMPTY;
    end else if (max_pat_q == '0 || pat_len_q > max_pat_q || 32'(pat_len_q) > PATTERN_MAX) begin
      status = STAT_OVER;
    end else begin
      status = STAT_OK;
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign idx_ok      = 32'(req_i.entry_index) < PATTERN_MAX;
  assign slot_free   = !rsp_valid_q || rsp_o.ready;
  assign cp_eq       = (cp_q == pat_rd_q);
  assign m_next      = m_q + CW'(cp_eq);
  assign cand_next   = cand_q + CW'(cp_eq);

  // span cell chain
  logic [OFFSET_BITS-1:0] c_start [PATTERN_MAX];
  logic [OFFSET_BITS-1:0] c_end   [PATTERN_MAX];
  logic [OFFSET_BITS-1:0] c_lo    [PATTERN_MAX];
  logic [OFFSET_BITS-1:0] c_hi    [PATTERN_MAX];
  logic shift;

  assign shift = accept && req_i.req_type == REQ_TEXT && !found_q && status == STAT_OK;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [OFFSET_BITS-1:0] up_start, up_end, dn_lo, dn_hi;
    if (k == 0) begin : g_head
      assign up_start = req_i.begin_ofs;
      assign up_end   = req_i.end_ofs;
    end else begin : g_mid
      assign up_start = c_start[k-1];
      assign up_end   = c_end[k-1];
    end
    if (k == PATTERN_MAX - 1) begin : g_tail
      assign dn_lo = '1;
      assign dn_hi = '0;
    end else begin : g_body
      assign dn_lo = c_lo[k+1];
      assign dn_hi = c_hi[k+1];
    end
    kcm_span_cell #(.OFFSET_BITS(OFFSET_BITS)) u_cell (
      .clk_i      (clk_i),
      .shift_i    (shift),
      .use_i      (32'(pat_len_q) > k),
      .in_start_i (up_start),
      .in_end_i   (up_end),
      .acc_lo_i   (dn_lo),
      .acc_hi_i   (dn_hi),
      .start_o    (c_start[k]),
      .end_o      (c_end[k]),
      .acc_lo_o   (c_lo[k]),
      .acc_hi_o   (c_hi[k])
    );
  end

  // next state and memory control
  always_comb begin
    state_d    = state_q;
    pat_we     = 1'b0;
    fail_we    = 1'b0;
    fail_wdata = '0;
    fail_waddr = AW'(32'(idx_q));
    pat_raddr  = AW'(m_q);
    fail_raddr = AW'(m_q - CW'(1));
    unique case (state_q)
      ST_IDLE: begin
        fail_waddr = AW'(32'(req_i.entry_index));
        if (accept) begin
          state_d = ST_DONE;
          if (req_i.req_type == REQ_LOAD && idx_ok) begin
            pat_we = 1'b1;
            if (req_i.entry_index == '0) begin
              fail_we = 1'b1;
            end else begin
              state_d = ST_L_RDF;
            end
          end else if (shift) begin
            state_d = ST_T_RD;
          end
        end
      end
      ST_T_RD:  state_d = ST_T_CMP;
      ST_T_CMP: begin
        if (m_q != '0 && !cp_eq) begin
          state_d = ST_T_RD;
        end else if (32'(m_next) == 32'(pat_len_q)) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_L_RDF: begin
        fail_raddr = AW'(32'(idx_q) - 32'd1);
        state_d    = ST_L_GETF;
      end
      ST_L_GETF: state_d = ST_L_RD;
      ST_L_RD: begin
        pat_raddr  = AW'(cand_q);
        fail_raddr = AW'(cand_q - CW'(1));
        state_d    = ST_L_CMP;
      end
      ST_L_CMP: begin
        if (cand_q != '0 && !cp_eq) begin
          state_d = ST_L_RD;
        end else begin
          fail_we    = 1'b1;
          fail_wdata = cand_next;
          state_d    = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (cnt_q == CW'(1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (pat_we) pat_mem[AW'(32'(req_i.entry_index))] <= req_i.codepoint;
    if (fail_we) fail_mem[fail_waddr] <= fail_wdata;
    pat_rd_q  <= pat_mem[pat_raddr];
    fail_rd_q <= fail_mem[fail_raddr];
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cp_q  <= req_i.codepoint;
      idx_q <= req_i.entry_index;
    end
    if (state_q == ST_L_GETF) begin
      cand_q <= (32'(fail_rd_q) >= 32'(idx_q)) ? '0 : fail_rd_q;
    end else if (state_q == ST_L_CMP) begin
      cand_q <= fail_rd_q;
    end
  end

  // state and scan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pat_len_q <= '0;
      max_pat_q <= MAX_PATTERN_RST;
      m_q       <= '0;
      cnt_q     <= '0;
      seen_q    <= '0;
      found_q   <= 1'b0;
      fstart_q  <= '0;
      fend_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_PATTERN_LENGTH: pat_len_q <= cfg_data_i;
          REG_MAX_PATTERN:    max_pat_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cfg_we_i || (accept && (req_i.req_type == REQ_LOAD ||
                                  req_i.req_type == REQ_RESTART))) begin
        m_q      <= '0;
        seen_q   <= '0;
        found_q  <= 1'b0;
        fstart_q <= '0;
        fend_q   <= '0;
      end else if (shift) begin
        if (seen_q != '1) seen_q <= seen_q + SEEN_W'(1);
      end
      if (state_q == ST_T_CMP) begin
        if (m_q != '0 && !cp_eq) begin
          m_q <= fail_rd_q;
        end else begin
          m_q   <= m_next;
          cnt_q <= CW'(PATTERN_MAX);
        end
      end
      if (state_q == ST_SCAN) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          found_q  <= 1'b1;
          fstart_q <= c_lo[0];
          fend_q   <= c_hi[0];
        end
      end
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && slot_free) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && slot_free) begin
      rsp_status_q <= status;
      rsp_found_q  <= found_q;
      rsp_start_q  <= fstart_q;
      rsp_end_q    <= fend_q;
      rsp_seen_q   <= seen_q;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found       = rsp_found_q;
  assign rsp_o.match_start = rsp_start_q;
  assign rsp_o.match_end   = rsp_end_q;
  assign rsp_o.seen_count  = rsp_seen_q;

endmodule

// File: hdl/kcm_checker.sv
// port-level checks for the matcher, bound to the top level
// depends on kcm_pkg and assert_macros.svh
`include "assert_macros.svh"

module kcm_checker #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [1:0]                 rsp_status_i,
  input logic                       rsp_found_i,
  input logic [OFFSET_BITS-1:0]     rsp_start_i,
  input logic [OFFSET_BITS-1:0]     rsp_end_i,
  input logic [kcm_pkg::SEEN_W-1:0] rsp_seen_i
);
  import kcm_pkg::*;

  logic rsp_stall, vld_found, vld_miss, span_zero;

  assign rsp_stall = rsp_valid_i && !rsp_ready_i;
  assign vld_found = rsp_valid_i && rsp_found_i;
  assign vld_miss  = rsp_valid_i && !rsp_found_i;
  assign span_zero = (rsp_start_i == '0) && (rsp_end_i == '0);

  // a stalled response keeps its count
  `KCM_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i && $stable(rsp_seen_i))
  // a match only exists under a valid pattern
  `KCM_ASSERT_IMP(a_found_ok, clk_i, rst_ni, vld_found, rsp_status_i == STAT_OK)
  // no match means zero span
  `KCM_ASSERT_IMP(a_nofound_zero, clk_i, rst_ni, vld_miss, span_zero)
  // a match needs at least one text code point
  `KCM_ASSERT_IMP(a_found_seen, clk_i, rst_ni, vld_found, rsp_seen_i != '0)

endmodule

bind kmp_codepoint_stream_matcher kcm_checker #(.OFFSET_BITS(OFFSET_BITS)) u_kcm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_found_i  (rsp_o.found),
  .rsp_start_i  (rsp_o.match_start),
  .rsp_end_i    (rsp_o.match_end),
  .rsp_seen_i   (rsp_o.seen_count)
);
